/* hdl/mipmap_box_downsample_core_macros.svh */
// ----------------------------------------------------------------------------
// mipmap_box_downsample_core_macros.svh
// Assertion macros for the mipmap box downsample core; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MIPMAP_BOX_DOWNSAMPLE_CORE_MACROS_SVH
`define MIPMAP_BOX_DOWNSAMPLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define MBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mbd assertion failed");
`define MBD_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mbd forbidden condition");
`else
`define MBD_ASSERT(lbl, prop)
`define MBD_ASSERT_NEVER(lbl, expr)
`endif

`endif

/* hdl/mbd_pkg.sv */
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types, constants, byte-lane average and format mask for the mipmap downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

  localparam int unsigned MAX_SOURCE_WIDTH_DEF = 4096;
  localparam int unsigned MAX_SOURCE_HEIGHT    = 4096;
  localparam int unsigned HEIGHT_W             = 13;
  localparam int unsigned ROW_W                = 12;
  localparam int unsigned CFG_DATA_W           = 13;
  localparam int unsigned CFG_INDEX_W          = 2;
  localparam int unsigned PIXEL_W              = 32;
  localparam int unsigned OUTQ_DEPTH           = 3;

  localparam logic [PIXEL_W-1:0] LANE_MASK = 32'hFEFE_FEFE;

  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT  = 2'd2;

  localparam logic [1:0] FMT_L8       = 2'd0;
  localparam logic [1:0] FMT_A8L8     = 2'd1;
  localparam logic [1:0] FMT_ARGB8888 = 2'd2;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } result_t;

  function automatic logic [PIXEL_W-1:0] lane_avg(input logic [PIXEL_W-1:0] a,
                                                  input logic [PIXEL_W-1:0] b);
    lane_avg = (((a ^ b) & LANE_MASK) >> 1) + (a & b);
  endfunction

  function automatic logic [PIXEL_W-1:0] fmt_mask(input logic [1:0] fmt);
    logic [PIXEL_W-1:0] m;
    unique case (fmt)
      FMT_L8:   m = 32'h0000_00FF;
      FMT_A8L8: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    fmt_mask = m;
  endfunction

endpackage

`default_nettype wire

/* hdl/mbd_ram.sv */
// ----------------------------------------------------------------------------
// mbd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/mbd_outq.sv */
// ----------------------------------------------------------------------------
// mbd_outq
// Small result queue decoupling the filter pipeline from output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_outq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mbd_pkg::result_t push_data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output mbd_pkg::result_t     data_o,
  output logic [1:0]           count_o
);

  localparam logic [1:0] LAST_SLOT = 2'(mbd_pkg::OUTQ_DEPTH - 1);

  mbd_pkg::result_t slot_q [mbd_pkg::OUTQ_DEPTH];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? 2'd0 : wr_ptr_q + 2'd1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_SLOT) ? 2'd0 : rd_ptr_q + 2'd1;
    end
    unique case ({push_i, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/mipmap_box_downsample_core.sv */
// ----------------------------------------------------------------------------
// mipmap_box_downsample_core
// 2x2 box filter producing the next mipmap level from a raster pixel stream.
// ----------------------------------------------------------------------------
// Throughput: one source pixel per cycle, sustained while the output drains.
// Result path: a result is registered into stage 1, where the line store read
//   completes, and then into the result queue, which drives mip_valid_o.
// Reset: counters zero, width 2, height 2, format ARGB8888; the line store is
//   not cleared, every entry is written in an even row before it is read.
`default_nettype none

`include "mipmap_box_downsample_core_macros.svh"

module mipmap_box_downsample_core #(
  parameter int unsigned MAX_SOURCE_WIDTH = mbd_pkg::MAX_SOURCE_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [mbd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             src_valid_i,
  output logic                                  src_ready_o,
  input  wire logic [mbd_pkg::PIXEL_W-1:0]      src_pixel_i,
  output logic                                  mip_valid_o,
  input  wire logic                             mip_ready_i,
  output logic      [mbd_pkg::PIXEL_W-1:0]      mip_pixel_o,
  output logic                                  last_pixel_o
);

  localparam int unsigned WW    = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int unsigned XW    = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned CW    = (WW > mbd_pkg::CFG_DATA_W) ? WW : mbd_pkg::CFG_DATA_W;
  localparam int unsigned DEPTH = MAX_SOURCE_WIDTH / 2;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned HW    = mbd_pkg::HEIGHT_W;
  localparam int unsigned YW    = mbd_pkg::ROW_W;
  localparam int unsigned PW    = mbd_pkg::PIXEL_W;

  // configuration, stored already clamped
  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [1:0]    fmt_q, fmt_d;
  logic          cfg_fire, cfg_known;
  logic [CW-1:0] cfg_ext;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_ext     = CW'(cfg_data_i);
  assign cfg_known   = (cfg_index_i == mbd_pkg::CFG_SOURCE_WIDTH)
                    || (cfg_index_i == mbd_pkg::CFG_SOURCE_HEIGHT)
                    || (cfg_index_i == mbd_pkg::CFG_PIXEL_FORMAT);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    fmt_d    = fmt_q;
    if (cfg_fire) begin
      priority if (cfg_index_i == mbd_pkg::CFG_SOURCE_WIDTH) begin
        if (cfg_data_i == '0) width_d = WW'(1);
        else if (cfg_ext > CW'(MAX_SOURCE_WIDTH)) width_d = WW'(MAX_SOURCE_WIDTH);
        else width_d = WW'(cfg_ext);
      end else if (cfg_index_i == mbd_pkg::CFG_SOURCE_HEIGHT) begin
        if (cfg_data_i == '0) height_d = HW'(1);
        else if (cfg_data_i > HW'(mbd_pkg::MAX_SOURCE_HEIGHT))
          height_d = HW'(mbd_pkg::MAX_SOURCE_HEIGHT);
        else height_d = cfg_data_i;
      end else if (cfg_index_i == mbd_pkg::CFG_PIXEL_FORMAT) begin
        fmt_d = cfg_data_i[1:0];
      end else begin
        fmt_d = fmt_q;
      end
    end
  end

  // position counters and the left/upper pixel hold
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [PW-1:0] hold_q, hold_d;

  logic [WW-1:0] col_ext, col_inc, used_w;
  logic [HW-1:0] row_ext, row_inc, used_h;
  logic          in_w, in_h, last_col, last_row;
  logic          one_by_one, h_only, v_only;
  logic          in_fire, hold_ld;
  logic [PW-1:0] mask, pix, pair;

  assign col_ext  = WW'(col_q);
  assign row_ext  = HW'(row_q);
  assign col_inc  = col_ext + WW'(1);
  assign row_inc  = row_ext + HW'(1);
  assign used_w   = {width_q[WW-1:1], 1'b0};
  assign used_h   = {height_q[HW-1:1], 1'b0};
  assign in_w     = col_ext < used_w;
  assign in_h     = row_ext < used_h;
  assign last_col = col_inc == used_w;
  assign last_row = row_inc == used_h;

  assign one_by_one = (width_q == WW'(1)) && (height_q == HW'(1));
  assign h_only     = height_q == HW'(1);
  assign v_only     = width_q == WW'(1);

  assign mask = mbd_pkg::fmt_mask(fmt_q);
  assign pix  = src_pixel_i & mask;
  assign pair = mbd_pkg::lane_avg(hold_q, pix);

  // stage 0 decisions
  logic          s0_res, s0_ram, s0_last, ram_we;
  logic [PW-1:0] s0_data;

  always_comb begin
    hold_ld = 1'b0;
    ram_we  = 1'b0;
    s0_res  = 1'b0;
    s0_ram  = 1'b0;
    s0_last = 1'b0;
    s0_data = pair;
    priority if (one_by_one) begin
      s0_res  = 1'b1;
      s0_last = 1'b1;
      s0_data = pix;
    end else if (h_only) begin
      if (in_w) begin
        if (!col_q[0]) hold_ld = 1'b1;
        else begin
          s0_res  = 1'b1;
          s0_last = last_col;
        end
      end
    end else if (v_only) begin
      if (in_h) begin
        if (!row_q[0]) hold_ld = 1'b1;
        else begin
          s0_res  = 1'b1;
          s0_last = last_row;
        end
      end
    end else if (in_w && in_h) begin
      if (!col_q[0]) hold_ld = 1'b1;
      else if (!row_q[0]) ram_we = 1'b1;
      else begin
        s0_res  = 1'b1;
        s0_ram  = 1'b1;
        s0_last = last_col && last_row;
      end
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    hold_d = hold_q;
    if (cfg_fire && cfg_known) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (hold_ld) hold_d = pix;
      if (col_inc == width_q) begin
        col_d = '0;
        row_d = (row_inc == height_q) ? '0 : YW'(row_inc);
      end else begin
        col_d = XW'(col_inc);
      end
    end
  end

  // line store: written in even rows, read in odd rows
  logic [XW:0]   col_half;
  logic [AW-1:0] ram_addr;
  logic [PW-1:0] ram_rdata;
  logic          ram_re;

  assign col_half = {1'b0, col_q} >> 1;
  assign ram_addr = col_half[AW-1:0];
  assign ram_re   = in_fire && s0_ram;

  mbd_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_fire && ram_we),
    .waddr_i (ram_addr),
    .wdata_i (pair),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // stage 1: finish the vertical average
  logic          s1_valid_q, s1_ram_q, s1_last_q;
  logic [PW-1:0] s1_data_q;
  mbd_pkg::result_t s1_result, q_data;
  logic [1:0]    q_count;

  assign s1_result.pixel = (s1_ram_q ? mbd_pkg::lane_avg(ram_rdata, s1_data_q)
                                     : s1_data_q) & mask;
  assign s1_result.last  = s1_last_q;

  assign src_ready_o = ({1'b0, q_count} + {2'b00, s1_valid_q}) < 3'(mbd_pkg::OUTQ_DEPTH);
  assign in_fire     = src_valid_i && src_ready_o;

  mbd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (s1_result),
    .valid_o     (mip_valid_o),
    .ready_i     (mip_ready_i),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  assign mip_pixel_o  = q_data.pixel;
  assign last_pixel_o = q_data.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WW'(2);
      height_q   <= HW'(2);
      fmt_q      <= mbd_pkg::FMT_ARGB8888;
      col_q      <= '0;
      row_q      <= '0;
      hold_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      fmt_q      <= fmt_d;
      col_q      <= col_d;
      row_q      <= row_d;
      hold_q     <= hold_d;
      s1_valid_q <= in_fire && s0_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s0_res) begin
      s1_ram_q  <= s0_ram;
      s1_last_q <= s0_last;
      s1_data_q <= s0_data;
    end
  end

  `MBD_ASSERT_NEVER(a_queue_overflow, s1_valid_q && (q_count == 2'(mbd_pkg::OUTQ_DEPTH)))
  `MBD_ASSERT(a_col_in_range, col_ext < width_q)
  `MBD_ASSERT(a_row_in_range, row_ext < height_q)
  `MBD_ASSERT(a_ram_read_issued, (s1_valid_q && s1_ram_q) |-> $past(ram_re))

endmodule

`default_nettype wire
